### src/asd_pkg.sv
// asd_pkg: shared types, constants and helper functions for the analog stick to d-pad block
// depends on nothing; imported by asd_rootdiv and analog_stick_to_dpad_core
`default_nettype none

package asd_pkg;

  localparam int SINE_BITS     = 20;
  localparam int PCT_BITS      = 7;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;
  localparam int DIR_BITS      = 4;
  localparam int KEY_BITS      = 4;

  localparam logic [SINE_BITS-1:0] SINE_SCALE      = 20'd1000000;
  localparam logic [PCT_BITS-1:0]  PERCENT_SCALE   = 7'd100;
  localparam logic [11:0]          SPAN_TOP_RESET  = 12'hFFF;
  localparam logic [PCT_BITS-1:0]  PCT_RESET       = 7'd50;
  localparam logic [SINE_BITS-1:0] SINE_LOW_RESET  = 20'd382683;
  localparam logic [SINE_BITS-1:0] SINE_HIGH_RESET = 20'd923880;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_MIN_START     = 3'd0,
    REG_X_MAX_START     = 3'd1,
    REG_Y_MIN_START     = 3'd2,
    REG_Y_MAX_START     = 3'd3,
    REG_DEAD_ZONE_PCT   = 3'd4,
    REG_SINE_LOW        = 3'd5,
    REG_SINE_HIGH       = 3'd6
  } reg_idx_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_NONE       = 4'd0,
    DIR_RIGHT      = 4'd1,
    DIR_RIGHT_UP   = 4'd2,
    DIR_UP         = 4'd3,
    DIR_LEFT_UP    = 4'd4,
    DIR_LEFT       = 4'd5,
    DIR_LEFT_DOWN  = 4'd6,
    DIR_DOWN       = 4'd7,
    DIR_RIGHT_DOWN = 4'd8
  } dir_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } rd_op_t;

  typedef struct packed {
    logic   start;
    rd_op_t op;
  } rd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CENTRE,
    S_MX,
    S_MY,
    S_MD,
    S_MN,
    S_RSTART,
    S_ROOT,
    S_MR,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

  // bit0 right, bit1 up, bit2 left, bit3 down
  function automatic logic [KEY_BITS-1:0] key_map(input dir_t d);
    logic [KEY_BITS-1:0] k;
    unique case (d)
      DIR_RIGHT:      k = 4'b0001;
      DIR_RIGHT_UP:   k = 4'b0011;
      DIR_UP:         k = 4'b0010;
      DIR_LEFT_UP:    k = 4'b0110;
      DIR_LEFT:       k = 4'b0100;
      DIR_LEFT_DOWN:  k = 4'b1100;
      DIR_DOWN:       k = 4'b1000;
      DIR_RIGHT_DOWN: k = 4'b1001;
      default:        k = 4'b0000;
    endcase
    return k;
  endfunction

  // equality with either threshold gives no direction
  function automatic dir_t pick_dir(input logic [SINE_BITS-1:0] s,
                                    input logic [SINE_BITS-1:0] lo,
                                    input logic [SINE_BITS-1:0] hi,
                                    input dir_t side,
                                    input dir_t diag,
                                    input dir_t vert);
    dir_t d;
    priority if (s < lo) d = side;
    else if (s > lo && s < hi) d = diag;
    else if (s > hi) d = vert;
    else d = DIR_NONE;
    return d;
  endfunction

endpackage

`default_nettype wire

### src/analog_stick_to_dpad_core.sv
// analog_stick_to_dpad_core: joystick sample pair to four-key d-pad with dead zone and auto-calibration
// depends on asd_pkg, asd_mul and asd_rootdiv
//
// One word in, one word out. Each x/y sample pair widens the per-axis calibration range, is
// centred, and its radius (floor square root) is tested against the dead zone; outside it the
// scaled sine |y|*1000000/radius picks one of eight directions, mapped to four key bits with the
// changed bits reported. The shared root/divide unit runs SAMPLE_BITS + 1 root steps and 20
// quotient steps, and each pair makes five passes through the shared multiplier; a pair in
// the dead zone skips the quotient steps. in_ready is high only between items; a finished
// word waits in the output register while the next pair is taken. Configuration writes are
// taken at any time but are meant for idle periods; writing a start register also reloads
// the matching calibration bound.
`default_nettype none

module analog_stick_to_dpad_core
  import asd_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    x_sample,
  input  logic [SAMPLE_BITS-1:0]    y_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DIR_BITS-1:0]       direction,
  output logic [KEY_BITS-1:0]       pressed_keys,
  output logic [KEY_BITS-1:0]       changed_keys,
  output logic                      sync_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB   = SAMPLE_BITS;
  localparam int RB   = SB + 1;
  localparam int AW   = SB + 1;
  localparam int BW   = SINE_BITS;
  localparam int MW   = AW + BW;
  localparam int SUMW = 2*SB + 1;
  localparam int NW   = SB + SINE_BITS;

  state_t state;
  state_t state_next;

  logic [SB-1:0]        x_low_seen;
  logic [SB-1:0]        x_high_seen;
  logic [SB-1:0]        y_low_seen;
  logic [SB-1:0]        y_high_seen;
  logic [PCT_BITS-1:0]  pct;
  logic [SINE_BITS-1:0] sine_low;
  logic [SINE_BITS-1:0] sine_high;
  logic [KEY_BITS-1:0]  key_bits;

  logic [SB-1:0]        xs;
  logic [SB-1:0]        ys;
  logic [SB-1:0]        ax;
  logic [SB-1:0]        ay;
  logic                 x_lt0;
  logic                 x_eq0;
  logic                 y_lt0;
  logic                 y_eq0;
  logic [SB-2:0]        mean;
  logic [SUMW-1:0]      sum;
  logic [MW-1:0]        dead_prod;
  logic [NW-1:0]        numer;
  logic [RB-1:0]        r;
  dir_t                 dir;

  logic                 in_acc;
  logic                 cfg_acc;
  logic                 ld_out;
  logic                 in_dead;

  logic [SB:0]          x_mid_sum;
  logic [SB:0]          y_mid_sum;
  logic [SB-1:0]        x_mid;
  logic [SB-1:0]        y_mid;
  logic [SB-2:0]        x_half;
  logic [SB-2:0]        y_half;
  logic [SB-1:0]        half_sum;

  logic [AW-1:0]        mul_a;
  logic [BW-1:0]        mul_b;
  logic [MW-1:0]        prod;

  rd_cmd_t              rd_cmd;
  rd_stat_t             rd_stat;
  logic [RB-1:0]        rd_root;
  logic [SINE_BITS-1:0] rd_quot;

  dir_t                 dir_pick;
  logic [KEY_BITS-1:0]  keys_new;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign ld_out    = (state == S_OUT) && (!out_valid || out_ready);

  // centring and dead zone span
  always_comb begin
    x_mid_sum = {1'b0, x_low_seen} + {1'b0, x_high_seen};
    y_mid_sum = {1'b0, y_low_seen} + {1'b0, y_high_seen};
    x_mid     = x_mid_sum[SB:1];
    y_mid     = y_mid_sum[SB:1];
    x_half    = (x_high_seen < x_low_seen) ? '0 : (SB-1)'((x_high_seen - x_low_seen) >> 1);
    y_half    = (y_high_seen < y_low_seen) ? '0 : (SB-1)'((y_high_seen - y_low_seen) >> 1);
    half_sum  = {1'b0, x_half} + {1'b0, y_half};
  end

  assign in_dead = (r == '0) || (prod <= dead_prod);

  // quadrant order: right-up, left-up, left-down, right-down
  always_comb begin
    priority if (!x_lt0 && !y_lt0)
      dir_pick = pick_dir(rd_quot, sine_low, sine_high, DIR_RIGHT, DIR_RIGHT_UP, DIR_UP);
    else if ((x_lt0 || x_eq0) && !y_lt0)
      dir_pick = pick_dir(rd_quot, sine_low, sine_high, DIR_LEFT, DIR_LEFT_UP, DIR_UP);
    else if ((x_lt0 || x_eq0) && (y_lt0 || y_eq0))
      dir_pick = pick_dir(rd_quot, sine_low, sine_high, DIR_LEFT, DIR_LEFT_DOWN, DIR_DOWN);
    else
      dir_pick = pick_dir(rd_quot, sine_low, sine_high, DIR_RIGHT, DIR_RIGHT_DOWN, DIR_DOWN);
  end

  assign keys_new = key_map(dir);

  // sequencer
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rd_cmd     = '{start: 1'b0, op: OP_SQRT};
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CENTRE;
      end
      S_CENTRE: begin
        state_next = S_MX;
      end
      S_MX: begin
        mul_a      = AW'(ax);
        mul_b      = BW'(ax);
        state_next = S_MY;
      end
      S_MY: begin
        mul_a      = AW'(ay);
        mul_b      = BW'(ay);
        state_next = S_MD;
      end
      S_MD: begin
        mul_a      = AW'(mean);
        mul_b      = BW'(pct);
        state_next = S_MN;
      end
      S_MN: begin
        mul_a      = AW'(ay);
        mul_b      = SINE_SCALE;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        rd_cmd     = '{start: 1'b1, op: OP_SQRT};
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (rd_stat.done) state_next = S_MR;
      end
      S_MR: begin
        mul_a      = AW'(r + 1'b1);
        mul_b      = BW'(PERCENT_SCALE);
        state_next = S_CHK;
      end
      S_CHK: begin
        if (in_dead) begin
          state_next = S_OUT;
        end else begin
          rd_cmd     = '{start: 1'b1, op: OP_DIV};
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (rd_stat.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // calibration, configuration, key state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_seen  <= '0;
      x_high_seen <= SB'(SPAN_TOP_RESET);
      y_low_seen  <= '0;
      y_high_seen <= SB'(SPAN_TOP_RESET);
      pct         <= PCT_RESET;
      sine_low    <= SINE_LOW_RESET;
      sine_high   <= SINE_HIGH_RESET;
      key_bits    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (reg_idx_t'(cfg_index))
          REG_X_MIN_START:   x_low_seen  <= cfg_data[SB-1:0];
          REG_X_MAX_START:   x_high_seen <= cfg_data[SB-1:0];
          REG_Y_MIN_START:   y_low_seen  <= cfg_data[SB-1:0];
          REG_Y_MAX_START:   y_high_seen <= cfg_data[SB-1:0];
          REG_DEAD_ZONE_PCT: pct         <= cfg_data[PCT_BITS-1:0];
          REG_SINE_LOW:      sine_low    <= cfg_data[SINE_BITS-1:0];
          REG_SINE_HIGH:     sine_high   <= cfg_data[SINE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (x_sample > x_high_seen) x_high_seen <= x_sample;
        if (x_sample < x_low_seen)  x_low_seen  <= x_sample;
        if (y_sample > y_high_seen) y_high_seen <= y_sample;
        if (y_sample < y_low_seen)  y_low_seen  <= y_sample;
      end
      if (ld_out) begin
        key_bits  <= keys_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xs <= x_sample;
      ys <= y_sample;
    end
    unique case (state)
      S_CENTRE: begin
        x_lt0 <= (xs < x_mid);
        x_eq0 <= (xs == x_mid);
        y_lt0 <= (ys > y_mid);
        y_eq0 <= (ys == y_mid);
        ax    <= (xs < x_mid) ? (x_mid - xs) : (xs - x_mid);
        ay    <= (ys < y_mid) ? (y_mid - ys) : (ys - y_mid);
        mean  <= half_sum[SB-1:1];
      end
      S_MY: begin
        sum <= SUMW'(prod);
      end
      S_MD: begin
        sum <= sum + SUMW'(prod);
      end
      S_MN: begin
        dead_prod <= prod;
      end
      S_RSTART: begin
        numer <= NW'(prod);
      end
      S_ROOT: begin
        if (rd_stat.done) r <= rd_root;
      end
      S_CHK: begin
        if (in_dead) dir <= DIR_NONE;
      end
      S_DIV: begin
        if (rd_stat.done) dir <= dir_pick;
      end
      default: ;
    endcase
    if (ld_out) begin
      direction    <= dir;
      changed_keys <= keys_new ^ key_bits;
      sync_flag    <= |(keys_new ^ key_bits);
    end
  end

  assign pressed_keys = key_bits;

  asd_mul #(
    .A_BITS(AW),
    .B_BITS(BW)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  asd_rootdiv #(
    .SAMPLE_BITS(SB)
  ) u_rootdiv (
    .clk      (clk),
    .rst      (rst),
    .cmd      (rd_cmd),
    .radicand (sum),
    .dividend (numer),
    .divisor  (r),
    .stat     (rd_stat),
    .root     (rd_root),
    .quotient (rd_quot)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("took a new word while one is in flight");

  a_calibration_covers: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !cfg_acc) |=>
      (x_low_seen <= $past(x_sample)) && (x_high_seen >= $past(x_sample)) &&
      (y_low_seen <= $past(y_sample)) && (y_high_seen >= $past(y_sample)))
    else $error("calibration range does not cover the sample");

  a_none_no_keys: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction == DIR_NONE) |-> (pressed_keys == '0))
    else $error("keys pressed with no direction");

  a_sync_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sync_flag == (changed_keys != '0)))
    else $error("sync flag disagrees with changed keys");
`endif

endmodule

`default_nettype wire

### src/asd_mul.sv
// asd_mul: shared multiplier with registered product
// depends on nothing; used by analog_stick_to_dpad_core for squares and scaled products
`default_nettype none

module asd_mul #(
  parameter int A_BITS = 13,
  parameter int B_BITS = 20
) (
  input  logic                       clk,
  input  logic [A_BITS-1:0]          a,
  input  logic [B_BITS-1:0]          b,
  output logic [A_BITS+B_BITS-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end

endmodule

`default_nettype wire

### src/asd_rootdiv.sv
// asd_rootdiv: iterative floor square root and restoring divider on one compare-subtract unit
// depends on asd_pkg; used by analog_stick_to_dpad_core
`default_nettype none

module asd_rootdiv
  import asd_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rd_cmd_t                           cmd,
  input  logic [2*SAMPLE_BITS:0]            radicand,
  input  logic [SAMPLE_BITS+SINE_BITS-1:0]  dividend,
  input  logic [SAMPLE_BITS:0]              divisor,
  output rd_stat_t                          stat,
  output logic [SAMPLE_BITS:0]              root,
  output logic [SINE_BITS-1:0]              quotient
);

  localparam int RB = SAMPLE_BITS + 1;
  localparam int W  = RB + 3;
  localparam int QW = (RB > SINE_BITS) ? RB : SINE_BITS;
  localparam int SW = (2*RB > SINE_BITS) ? 2*RB : SINE_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [W-1:0]  rem;
  logic [QW-1:0] q;
  logic [SW-1:0] src;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  rd_op_t        op;

  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  diff;
  logic          ge;

  // shared compare-subtract unit
  always_comb begin
    if (op == OP_SQRT) begin
      a = {rem[W-3:0], src[SW-1 -: 2]};
      b = W'({q[RB-1:0], 2'b01});
    end else begin
      a = {rem[W-2:0], src[SW-1]};
      b = W'(divisor);
    end
    diff = a - b;
    ge   = (a >= b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        q    <= '0;
        if (cmd.op == OP_SQRT) begin
          cnt <= CW'(RB);
          rem <= '0;
          src <= SW'(radicand) << (SW - 2*RB);
        end else begin
          cnt <= CW'(SINE_BITS);
          // quotient fits in SINE_BITS, so the upper part is already below the divisor
          rem <= W'(dividend[SAMPLE_BITS+SINE_BITS-1:SINE_BITS]);
          src <= SW'(dividend[SINE_BITS-1:0]) << (SW - SINE_BITS);
        end
      end else if (busy) begin
        rem <= ge ? diff : a;
        q   <= {q[QW-2:0], ge};
        src <= (op == OP_SQRT) ? (src << 2) : (src << 1);
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign root     = q[RB-1:0];
  assign quotient = q[SINE_BITS-1:0];

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy)
    else $error("rootdiv started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("rootdiv done while still busy");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !cmd.start && cnt == CW'(1)) |=> (done && !busy))
    else $error("rootdiv missed its final step");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench for analog_stick_to_dpad_core: directed and random stick sample pairs under many
// calibration, dead zone and threshold settings, each d-pad word checked by a scoreboard
// depends on asd_pkg and on the core with its submodules

import asd_pkg::*;

localparam int STICK_BITS = 12;

typedef struct {
  dir_t                dir;
  logic [KEY_BITS-1:0] pressed;
  logic [KEY_BITS-1:0] changed;
  logic                sync;
} dpad_word_t;

class dpad_scoreboard;
  logic [STICK_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [PCT_BITS-1:0]   pct;
  logic [SINE_BITS-1:0]  s_lo, s_hi;
  logic [KEY_BITS-1:0]   held_keys;
  dpad_word_t            expected_words[$];
  int                    errors;
  int                    words_checked;
  logic [8:0]            dirs_seen;

  function new();
    x_lo = '0;
    x_hi = '1;
    y_lo = '0;
    y_hi = '1;
    pct = 7'd50;
    s_lo = 20'd382683;
    s_hi = 20'd923880;
    held_keys = '0;
    errors = 0;
    words_checked = 0;
    dirs_seen = '0;
  endfunction

  function void set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_X_MIN_START:   x_lo = d[STICK_BITS-1:0];
      REG_X_MAX_START:   x_hi = d[STICK_BITS-1:0];
      REG_Y_MIN_START:   y_lo = d[STICK_BITS-1:0];
      REG_Y_MAX_START:   y_hi = d[STICK_BITS-1:0];
      REG_DEAD_ZONE_PCT: pct = d[PCT_BITS-1:0];
      REG_SINE_LOW:      s_lo = d[SINE_BITS-1:0];
      REG_SINE_HIGH:     s_hi = d[SINE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function longint floor_root(input longint v);
    longint r;
    longint b;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      b = r | (longint'(1) << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function dir_t classify(input longint s, input dir_t side, input dir_t diag, input dir_t vert);
    longint lo;
    longint hi;
    lo = longint'(s_lo);
    hi = longint'(s_hi);
    if (s < lo) return side;
    if (s > lo && s < hi) return diag;
    if (s > hi) return vert;
    return DIR_NONE;
  endfunction

  function logic [KEY_BITS-1:0] keys_for(input dir_t d);
    logic [KEY_BITS-1:0] k;
    k[0] = (d == DIR_RIGHT || d == DIR_RIGHT_UP || d == DIR_RIGHT_DOWN);
    k[1] = (d == DIR_RIGHT_UP || d == DIR_UP || d == DIR_LEFT_UP);
    k[2] = (d == DIR_LEFT_UP || d == DIR_LEFT || d == DIR_LEFT_DOWN);
    k[3] = (d == DIR_LEFT_DOWN || d == DIR_DOWN || d == DIR_RIGHT_DOWN);
    return k;
  endfunction

  function void note_pair(input logic [STICK_BITS-1:0] xs, input logic [STICK_BITS-1:0] ys);
    longint x, y, ax, ay, r, s, hx, hy, dead;
    dir_t d;
    dpad_word_t w;
    if (xs > x_hi) x_hi = xs;
    if (xs < x_lo) x_lo = xs;
    if (ys > y_hi) y_hi = ys;
    if (ys < y_lo) y_lo = ys;
    x = longint'(xs) - (longint'(x_lo) + longint'(x_hi)) / 2;
    y = (longint'(y_lo) + longint'(y_hi)) / 2 - longint'(ys);
    hx = (x_hi < x_lo) ? 0 : (longint'(x_hi) - longint'(x_lo)) / 2;
    hy = (y_hi < y_lo) ? 0 : (longint'(y_hi) - longint'(y_lo)) / 2;
    dead = longint'(pct) * ((hx + hy) / 2) / 100;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    r = floor_root(ax * ax + ay * ay);
    if (r == 0 || r < dead) begin
      d = DIR_NONE;
    end else begin
      s = ay * 1000000 / r;
      if (x >= 0 && y >= 0) d = classify(s, DIR_RIGHT, DIR_RIGHT_UP, DIR_UP);
      else if (x <= 0 && y >= 0) d = classify(s, DIR_LEFT, DIR_LEFT_UP, DIR_UP);
      else if (x <= 0 && y <= 0) d = classify(s, DIR_LEFT, DIR_LEFT_DOWN, DIR_DOWN);
      else d = classify(s, DIR_RIGHT, DIR_RIGHT_DOWN, DIR_DOWN);
    end
    w.dir = d;
    w.pressed = keys_for(d);
    w.changed = w.pressed ^ held_keys;
    w.sync = |w.changed;
    held_keys = w.pressed;
    expected_words.push_back(w);
  endfunction

  function void check_result(input logic [DIR_BITS-1:0] dir, input logic [KEY_BITS-1:0] pressed,
                             input logic [KEY_BITS-1:0] changed, input logic sync);
    dpad_word_t w;
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= 200)
        $display("%0t: word with none expected, direction %0d keys %b", $time, dir, pressed);
      return;
    end
    w = expected_words.pop_front();
    words_checked++;
    dirs_seen[w.dir] = 1'b1;
    if (dir !== w.dir) begin
      errors++;
      if (errors <= 200)
        $display("%0t: direction expected %0d actual %0d", $time, w.dir, dir);
    end
    if (pressed !== w.pressed) begin
      errors++;
      if (errors <= 200)
        $display("%0t: pressed_keys expected %b actual %b", $time, w.pressed, pressed);
    end
    if (changed !== w.changed) begin
      errors++;
      if (errors <= 200)
        $display("%0t: changed_keys expected %b actual %b", $time, w.changed, changed);
    end
    if (sync !== w.sync) begin
      errors++;
      if (errors <= 200)
        $display("%0t: sync_flag expected %b actual %b", $time, w.sync, sync);
    end
  endfunction
endclass

module testbench;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_PAIRS = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STICK_BITS-1:0] x_sample = '0;
  logic [STICK_BITS-1:0] y_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIR_BITS-1:0] direction;
  logic [KEY_BITS-1:0] pressed_keys;
  logic [KEY_BITS-1:0] changed_keys;
  logic sync_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  dpad_scoreboard sb;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int settings_run = 0;
  int pairs_sent = 0;

  analog_stick_to_dpad_core #(.SAMPLE_BITS(STICK_BITS)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_reg(idx, d);
  endtask

  task automatic write_setting(input logic [CFG_DATA_BITS-1:0] xmin, xmax, ymin, ymax,
                               input logic [CFG_DATA_BITS-1:0] pctv, slo, shi);
    cfg_write(REG_X_MIN_START, xmin);
    cfg_write(REG_X_MAX_START, xmax);
    cfg_write(REG_Y_MIN_START, ymin);
    cfg_write(REG_Y_MAX_START, ymax);
    cfg_write(REG_DEAD_ZONE_PCT, pctv);
    cfg_write(REG_SINE_LOW, slo);
    cfg_write(REG_SINE_HIGH, shi);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic send_pair(input logic [STICK_BITS-1:0] xs, input logic [STICK_BITS-1:0] ys);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_pair(xs, ys);
    pairs_sent++;
  endtask

  // stop offering pairs until every predicted word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  task automatic random_setting();
    logic [CFG_DATA_BITS-1:0] xmin, xmax, ymin, ymax, pctv, slo, shi;
    int rx, ry;
    case ($urandom_range(0, 3))
      0: begin
        xmin = 0; xmax = 4095; ymin = 0; ymax = 4095;
      end
      1: begin
        rx = $urandom_range(0, 600);
        ry = $urandom_range(0, 600);
        xmin = 20'(2047 - rx); xmax = 20'(2047 + rx);
        ymin = 20'(2047 - ry); ymax = 20'(2047 + ry);
      end
      2: begin
        xmin = 20'($urandom()); xmax = 20'($urandom());
        ymin = 20'($urandom()); ymax = 20'($urandom());
      end
      default: begin
        xmin = 20'($urandom_range(0, 4095));
        xmax = xmin; ymin = xmin; ymax = xmin;
      end
    endcase
    case ($urandom_range(0, 4))
      0: pctv = 0;
      1: pctv = 100;
      2: pctv = 20'($urandom());
      default: pctv = 20'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 4))
      0: begin
        slo = 382683; shi = 923880;
      end
      1: begin
        slo = 20'($urandom_range(0, 1000000));
        shi = 20'($urandom_range(slo, 1000000));
      end
      2: begin
        slo = 0; shi = 1000000;
      end
      3: begin
        slo = 20'($urandom()); shi = 20'($urandom());
      end
      default: begin
        slo = 20'($urandom_range(0, 1000000)); shi = slo;
      end
    endcase
    write_setting(xmin, xmax, ymin, ymax, pctv, slo, shi);
  endtask

  task automatic random_pair();
    logic [STICK_BITS-1:0] xs, ys;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        xs = 12'($urandom()); ys = 12'($urandom());
      end
      4, 5: begin
        xs = 12'(1847 + $urandom_range(0, 400));
        ys = 12'(1847 + $urandom_range(0, 400));
      end
      6: begin
        xs = 12'($urandom()); ys = 12'($urandom());
        if ($urandom_range(0, 1)) xs = 2047;
        else ys = 2047;
      end
      7: begin
        xs = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        ys = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
      default: begin
        xs = 12'(2039 + $urandom_range(0, 16));
        ys = 12'(2039 + $urandom_range(0, 16));
      end
    endcase
    send_pair(xs, ys);
  endtask

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_result(direction, pressed_keys, changed_keys, sync_flag);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default calibration, all eight directions, centre and dead zone edge
    write_setting(0, 4095, 0, 4095, 50, 382683, 923880);
    send_pair(2047, 2047);
    send_pair(4095, 2047);
    send_pair(0, 2047);
    send_pair(2047, 0);
    send_pair(2047, 4095);
    send_pair(4095, 0);
    send_pair(0, 0);
    send_pair(0, 4095);
    send_pair(4095, 4095);
    send_pair(2100, 1990);
    send_pair(3077, 2047);

    // zero dead zone, zero radius, sine equal to the low threshold; wide data masked
    drain();
    cfg_write(REG_SPARE, 20'hFFFFF);
    write_setting(20'hFF000, 20'hFFFFF, 20'h01000, 20'hFFFFF, 0, 800000, 900000);
    send_pair(2047, 2047);
    send_pair(2050, 2051);
    send_pair(2050, 2043);

    // sine equal to the high threshold
    drain();
    write_setting(0, 4095, 0, 4095, 0, 700000, 800000);
    send_pair(2050, 2043);
    send_pair(2044, 2043);
    send_pair(2051, 2044);

    // inverted start range, full dead zone, thresholds at the extremes
    drain();
    write_setting(4000, 100, 0, 4095, 100, 0, 1000000);
    send_pair(4095, 0);
    send_pair(0, 2047);
    send_pair(0, 0);

    // percent above 100
    drain();
    write_setting(0, 4095, 0, 4095, 127, 382683, 923880);
    send_pair(4095, 2047);
    send_pair(0, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      random_setting();
      idle_on = (p % 4 != 2);
      if (p == 4) begin
        idle_on = 1'b0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        if ($urandom_range(0, 59) == 0) drain();
        random_pair();
      end
    end

    idle_on = 1'b1;
    drain();
    repeat (100) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d words never arrived", $time, sb.expected_words.size());
    end
    $display("sent %0d stick pairs under %0d register settings, %0d words checked",
             pairs_sent, settings_run, sb.words_checked);
    $display("direction codes seen (bit per code): %b, mismatches %0d", sb.dirs_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout after %0t with %0d words outstanding", $time, sb.expected_words.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
